[rtl/psc_pkg.sv]
package psc_pkg;

  localparam int NUM_ENTRIES    = 32;
  localparam int STEPS_PER_TURN = 200;
  localparam int NUM_LEDS       = 32;
  localparam int ARROW_SHIFT    = 30;

  localparam int ENTRY_AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef enum logic [2:0] {
    SHAPE_CIRCLE = 3'd0,
    SHAPE_ARC    = 3'd1,
    SHAPE_LINE   = 3'd2,
    SHAPE_BOX    = 3'd3,
    SHAPE_SOLID  = 3'd4,
    SHAPE_ARROW  = 3'd5,
    SHAPE_POINT  = 3'd6
  } shape_kind_t;

  typedef struct packed {
    logic [7:0] end_stp;
    logic [7:0] start_stp;
    logic [4:0] outer_radius;
    logic [4:0] inner_radius;
    logic [2:0] shape_color;
    logic [2:0] shape_type;
  } shape_entry_t;

  // Reduces an 8-bit step to the range of one turn (input never reaches twice the turn).
  function automatic logic [7:0] mod_steps(input logic [7:0] x);
    logic [8:0] wide;
    wide = {1'b0, x};
    if (wide >= 9'(STEPS_PER_TURN)) begin
      wide = wide - 9'(STEPS_PER_TURN);
    end
    return wide[7:0];
  endfunction

  // Lights every radius from lo to hi that exists on the display.
  function automatic logic [31:0] range_mask(input logic signed [10:0] lo,
                                             input logic signed [10:0] hi);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 32; i++) begin
      m[i] = (i < NUM_LEDS) && ($signed(11'(i)) >= lo) && ($signed(11'(i)) <= hi);
    end
    return m;
  endfunction

endpackage

[rtl/psc_table.sv]
module psc_table (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [4:0]            wr_idx,
  input  psc_pkg::shape_entry_t wr_data,
  input  logic                  rd_en,
  input  logic [4:0]            rd_idx,
  output psc_pkg::shape_entry_t rd_data
);
  import psc_pkg::*;

  shape_entry_t entry_r [NUM_ENTRIES];
  shape_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_idx[ENTRY_AW-1:0]] <= wr_data;
    end
  end

  // A write retiring on the same edge as the read is passed straight through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_idx == rd_idx) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= entry_r[rd_idx[ENTRY_AW-1:0]];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/psc_render.sv]
module psc_render (
  input  psc_pkg::shape_entry_t entry,
  input  logic [7:0]            rotor,
  output logic [31:0]           mask
);
  import psc_pkg::*;

  logic [7:0]         s;
  logic [7:0]         e;
  logic [7:0]         t;
  logic               wrap;
  logic               open_span;
  logic               closed_span;
  logic               arrow_span;
  logic               adjacent;
  logic [7:0]         ts;
  logic [7:0]         ss;
  logic [7:0]         es;
  logic signed [10:0] diff;
  logic signed [10:0] lim;
  logic signed [10:0] r_s;
  logic signed [10:0] big_r_s;
  logic [31:0]        full_mask;
  logic [31:0]        inner_bit;
  logic [31:0]        outer_bit;

  assign s    = entry.start_stp;
  assign e    = entry.end_stp;
  assign t    = rotor;
  assign wrap = s > e;

  assign open_span   = wrap ? (t > s || t < e) : (t > s && t < e);
  assign closed_span = wrap ? (t > s || t < e) : (t >= s && t <= e);
  assign arrow_span  = (s == e) ? (t == s) :
                       (s < e)  ? (t >= s && t <= e) : (t >= s || t <= e);

  // Neighbors of the start step, counting across the end of the turn.
  assign adjacent = ({1'b0, s} == {1'b0, t} + 9'd1) || ({1'b0, t} == {1'b0, s} + 9'd1) ||
                    (s == 8'd0 && t == 8'(STEPS_PER_TURN - 1)) ||
                    (t == 8'd0 && s == 8'(STEPS_PER_TURN - 1));

  // A wrapped arrow is measured on steps rotated forward by a fixed offset.
  assign ts = wrap ? mod_steps(t + 8'(ARROW_SHIFT)) : t;
  assign ss = wrap ? mod_steps(s + 8'(ARROW_SHIFT)) : s;
  assign es = wrap ? mod_steps(e + 8'(ARROW_SHIFT)) : e;

  assign diff = $signed({2'b00, ts, 1'b0}) - $signed({3'b000, ss}) - $signed({3'b000, es});
  assign lim  = (diff < 0) ? -diff : diff;

  assign r_s     = $signed({6'd0, entry.inner_radius});
  assign big_r_s = $signed({6'd0, entry.outer_radius});

  assign full_mask = range_mask(r_s, big_r_s);
  assign inner_bit = range_mask(r_s, r_s);
  assign outer_bit = range_mask(big_r_s, big_r_s);

  always_comb begin
    mask = '0;
    unique case (entry.shape_type)
      SHAPE_CIRCLE: mask = inner_bit;
      SHAPE_ARC: begin
        if (open_span) mask = inner_bit;
      end
      SHAPE_LINE: begin
        if (t == s) mask = full_mask;
      end
      SHAPE_BOX: begin
        if (t == s || t == e) mask = full_mask;
        if (open_span) mask = mask | inner_bit | outer_bit;
      end
      SHAPE_SOLID: begin
        if (closed_span) mask = full_mask;
      end
      SHAPE_ARROW: begin
        if (arrow_span) mask = range_mask(r_s, big_r_s - lim);
      end
      SHAPE_POINT: begin
        if (adjacent) mask = range_mask(r_s - 11'sd2, r_s);
        if (t == s) mask = mask | range_mask(r_s - 11'sd1, r_s + 11'sd1);
      end
      default: mask = '0;
    endcase
  end

endmodule

[rtl/polar_shape_column_render.sv]
// Shape table and column renderer for a rotating LED display.
// Input channel (in_valid / in_stall): each transaction either writes one
// shape entry (in_action = write) or renders one entry at a rotor step
// (in_action = render). Writes produce no result; each render produces one
// result transaction on the output channel (out_valid / out_stall) carrying
// the 32-bit mask of lit radii and the entry's stored color.
// A render result passes from the input register and the table read register,
// both loaded by the accepting edge, into the result register, which is loaded
// when the render leaves the input register.
// Throughput is one transaction per cycle while the receiver does not stall;
// only the shape logic sits between the input stage and the result register.
// A render observes every write accepted before it, including the one in
// the immediately preceding cycle.
// Reset clears the valid flags only; table contents are undefined until
// written. When the receiver stalls, the result is held in the output
// register, one more render waits in the input register, and in_stall rises;
// writes keep draining while the output is stalled.
module polar_shape_column_render (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [4:0]  in_entry_index,
  input  logic [2:0]  in_shape_type,
  input  logic [2:0]  in_shape_color,
  input  logic [4:0]  in_inner_radius,
  input  logic [4:0]  in_outer_radius,
  input  logic [7:0]  in_start_step,
  input  logic [7:0]  in_end_step,
  input  logic [7:0]  in_rotor_step,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_lit_mask,
  output logic [2:0]  out_lit_color
);
  import psc_pkg::*;

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  logic         s1_action_r;
  logic [4:0]   s1_idx_r;
  shape_entry_t s1_entry_r;
  logic [7:0]   s1_rotor_r;

  logic         out_valid_r;
  logic         out_valid_nxt;
  logic [31:0]  out_mask_r;
  logic [2:0]   out_color_r;

  logic         accept;
  logic         out_free;
  logic         s1_adv;
  logic         idx_ok;
  logic         tbl_wr_en;
  shape_entry_t rd_entry;
  logic [31:0]  render_mask;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (s1_action_r == ACT_WRITE || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign idx_ok    = 32'(s1_idx_r) < 32'(NUM_ENTRIES);
  assign tbl_wr_en = s1_adv && s1_action_r == ACT_WRITE && idx_ok;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_action_r == ACT_RENDER) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Steps are folded into one turn here so the table holds reduced values.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r             <= in_action;
      s1_idx_r                <= in_entry_index;
      s1_entry_r.shape_type   <= in_shape_type;
      s1_entry_r.shape_color  <= in_shape_color;
      s1_entry_r.inner_radius <= in_inner_radius;
      s1_entry_r.outer_radius <= in_outer_radius;
      s1_entry_r.start_stp    <= mod_steps(in_start_step);
      s1_entry_r.end_stp      <= mod_steps(in_end_step);
      s1_rotor_r              <= mod_steps(in_rotor_step);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_action_r == ACT_RENDER) begin
      out_mask_r  <= idx_ok ? render_mask : '0;
      out_color_r <= idx_ok ? rd_entry.shape_color : 3'd0;
    end
  end

  psc_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_idx  (s1_idx_r),
    .wr_data (s1_entry_r),
    .rd_en   (accept),
    .rd_idx  (in_entry_index),
    .rd_data (rd_entry)
  );

  psc_render u_render (
    .entry (rd_entry),
    .rotor (s1_rotor_r),
    .mask  (render_mask)
  );

  assign out_valid     = out_valid_r;
  assign out_lit_mask  = out_mask_r;
  assign out_lit_color = out_color_r;

endmodule
